@@ rtl/wrv_pkg.sv @@
package wrv_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int DELTA_W   = SAMPLE_W + 1;
  localparam int COUNT_BITS = 32;
  localparam int COUNT_OUT_W = 32;
  localparam int ALU_W     = 64;
  localparam int DIVISOR_W = 32;
  localparam int STEP_W    = $clog2(ALU_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_VAR_GO,
    S_VAR_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [STEP_W-1:0] steps;
  } alu_cmd_t;

endpackage

@@ rtl/wrv_alu.sv @@
module wrv_alu (
  input  logic                    clk,
  input  logic                    rst,
  input  wrv_pkg::alu_cmd_t       cmd,
  input  logic [wrv_pkg::ALU_W-1:0] a,
  input  logic [wrv_pkg::ALU_W-1:0] b,
  output logic                    done,
  output logic [wrv_pkg::ALU_W-1:0] result
);
  import wrv_pkg::*;

  logic [ALU_W-1:0]  acc;
  logic [ALU_W-1:0]  sh;
  logic [ALU_W-1:0]  opb;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  alu_op_t           op;

  logic [ALU_W-1:0] add_x;
  logic [ALU_W-1:0] add_y;
  logic             add_cin;
  logic [ALU_W:0]   sum;
  logic             ge;

  always_comb begin
    if (op == ALU_DIV) begin
      add_x   = ALU_W'({acc[DIVISOR_W-1:0], sh[ALU_W-1]});
      add_y   = ~opb;
      add_cin = 1'b1;
    end else begin
      add_x   = acc;
      add_y   = opb;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_x} + {1'b0, add_y} + (ALU_W+1)'(add_cin);
    ge  = sum[ALU_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= ALU_DIV;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
        op   <= cmd.op;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
      sh  <= a;
      opb <= b;
    end else if (busy) begin
      if (op == ALU_DIV) begin
        acc <= ge ? sum[ALU_W-1:0] : add_x;
        sh  <= {sh[ALU_W-2:0], ge};
      end else begin
        if (sh[0]) begin
          acc <= sum[ALU_W-1:0];
        end
        opb <= {opb[ALU_W-2:0], 1'b0};
        sh  <= {1'b0, sh[ALU_W-1:1]};
      end
    end
  end

  assign result = (op == ALU_DIV) ? sh : acc;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy && !done)
    else $error("unit not busy after start");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

endmodule

@@ rtl/welford_running_variance.sv @@
// Welford running mean and variance over signed Q16.16 samples. One item is
// in flight at a time: in_ready is high only while the block is idle, and a
// finished result waits in the output register while the next item is taken.
// The single shared add/subtract unit does the work in order: 33 steps for the
// mean division, 33 for the shift-add product and 64 for the variance division,
// which is skipped while fewer than two samples have been seen. The output
// register is loaded once it is free, and the next item can be taken after the
// block returns to idle. Count and M2 saturate; saturated is sticky until reset.
module welford_running_variance (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample_count,
  output logic signed [31:0] running_mean,
  output logic [63:0] sample_variance,
  output logic        saturated
);
  import wrv_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  state_t state, state_next;

  logic [COUNT_BITS-1:0]      count;
  logic signed [SAMPLE_W-1:0] mean_acc;
  logic [ALU_W-1:0]           sq_dev_sum;
  logic                       sat_flag;
  logic signed [SAMPLE_W-1:0] x;
  logic [DELTA_W-1:0]         mag_d;
  logic                       neg_d;

  alu_cmd_t         cmd;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_done;
  logic [ALU_W-1:0] alu_result;

  logic                      accept;
  logic [COUNT_BITS-1:0]     count_next;
  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] delta2;
  logic [DELTA_W-1:0]        mag2;
  logic [DELTA_W-1:0]        q;
  logic signed [DELTA_W:0]   mean_wide;
  logic [ALU_W:0]            m2_sum;
  logic                      few;

  wrv_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .a      (alu_a),
    .b      (alu_b),
    .done   (alu_done),
    .result (alu_result)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign few      = (count < COUNT_BITS'(2));

  always_comb begin
    count_next = (count != COUNT_MAX) ? count + COUNT_BITS'(1) : count;
    delta      = DELTA_W'(sample) - DELTA_W'(mean_acc);
    delta2     = DELTA_W'(x) - DELTA_W'(mean_acc);
    mag2       = delta2[DELTA_W-1] ? DELTA_W'(-delta2) : DELTA_W'(delta2);
    q          = alu_result[DELTA_W-1:0];
    mean_wide  = (DELTA_W+1)'(mean_acc)
               + (neg_d ? -(DELTA_W+1)'(q) : (DELTA_W+1)'(q));
    m2_sum     = {1'b0, sq_dev_sum} + {1'b0, alu_result};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.op     = ALU_DIV;
    cmd.steps  = STEP_W'(DELTA_W);
    alu_a      = {mag_d, (ALU_W-DELTA_W)'(0)};
    alu_b      = ALU_W'(count);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MEAN_GO;
        end
      end
      S_MEAN_GO: begin
        cmd.start  = 1'b1;
        state_next = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (alu_done) begin
          state_next = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = ALU_MUL;
        alu_a      = ALU_W'(mag_d);
        alu_b      = ALU_W'(mag2);
        state_next = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (alu_done) begin
          state_next = S_VAR_GO;
        end
      end
      S_VAR_GO: begin
        cmd.start  = !few;
        cmd.steps  = STEP_W'(ALU_W);
        alu_a      = sq_dev_sum;
        alu_b      = ALU_W'(count - COUNT_BITS'(1));
        state_next = few ? S_FINISH : S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (alu_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      mean_acc   <= '0;
      sq_dev_sum <= '0;
      sat_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        if (count_next == COUNT_MAX) begin
          sat_flag <= 1'b1;
        end
      end
      if (state == S_MEAN_WAIT && alu_done) begin
        mean_acc <= mean_wide[SAMPLE_W-1:0];
      end
      if (state == S_MUL_WAIT && alu_done) begin
        if (m2_sum[ALU_W]) begin
          sq_dev_sum <= '1;
          sat_flag   <= 1'b1;
        end else begin
          sq_dev_sum <= m2_sum[ALU_W-1:0];
        end
      end
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x     <= sample;
      neg_d <= delta[DELTA_W-1];
      mag_d <= delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
    end
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      sample_count    <= COUNT_OUT_W'(count);
      running_mean    <= mean_acc;
      sample_variance <= few ? '0 : alu_result;
      saturated       <= sat_flag;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MEAN_GO)
    else $error("item accepted without starting work");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    sat_flag |=> sat_flag)
    else $error("saturation flag dropped");

  a_var_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count < 32'd2 |-> sample_variance == '0)
    else $error("variance nonzero below two samples");

endmodule
